>>> hdl/ms_pkg.sv
package ms_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN,
        ST_READ,
        ST_MERGE,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

endpackage

>>> hdl/merge_sorter_core.sv
// Channel  | Ports      | tdata (lowest bit up)    | tlast     | tuser
// ---------+------------+--------------------------+-----------+---------
// input    | s_axis_*   | value [31:0] signed      | last      | -
// result   | m_axis_*   | sorted_value [31:0] sgnd | final_res | overflow
//
// Loading takes one cycle per item; items past DEPTH are dropped and flagged.
// The sort makes ceil(log2(n)) bottom-up merge passes between two memories,
// each pass handling one element at a time (read, then compare and write)
// with a setup state before and a close-out state after each run.
// Each result is read, then registered; m_axis_tready stalls can hold it.
// Reset is synchronous and active low; the memories need no clearing pass.
module merge_sorter_core
    import ms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // value [31:0]
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // sorted_value [31:0]
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic              sel_reg, sel_next;
    logic [PW-1:0]     w_reg, w_next;
    logic [PW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     mid_reg, mid_next;
    logic [PW-1:0]     hi_reg, hi_next;
    logic [PW-1:0]     i_reg, i_next;
    logic [PW-1:0]     j_reg, j_next;
    logic [PW-1:0]     k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              in_acc;
    logic              load_we;
    logic              merge_we;
    logic [DATA_W-1:0] merge_data;
    logic              take_left;
    logic [PW-1:0]     n_ext;
    logic [PW-1:0]     lo_w, lo_2w, lo_adv, w_dbl;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b, src_a, src_b;
    logic              we0, we1;
    logic [AW-1:0]     waddr0;
    logic [DATA_W-1:0] wdata0;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_we       = in_acc && (count_reg < DEPTH_C);
    assign n_ext         = PW'(count_reg);

    assign src_a = sel_reg ? rd1_a : rd0_a;
    assign src_b = sel_reg ? rd1_b : rd0_b;

    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_left ? src_a : src_b;
    assign merge_we   = (state_reg == ST_MERGE);

    assign lo_w   = lo_reg + w_reg;
    assign lo_2w  = lo_reg + (w_reg << 1);
    assign lo_adv = lo_reg + (w_reg << 1);
    assign w_dbl  = w_reg << 1;

    assign raddr_a = (state_reg == ST_OUT_RD || state_reg == ST_OUT_WR) ?
                     k_reg[AW-1:0] : i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];

    assign we0    = load_we || (merge_we && sel_reg);
    assign we1    = merge_we && !sel_reg;
    assign waddr0 = (state_reg == ST_LOAD) ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wdata0 = (state_reg == ST_LOAD) ? s_axis_tdata : merge_data;

    ms_ram #(.DEPTH(DEPTH)) u_ram0 (
        .aclk    (aclk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (wdata0),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    ms_ram #(.DEPTH(DEPTH)) u_ram1 (
        .aclk    (aclk),
        .we      (we1),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_data),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        sel_next       = sel_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (load_we) begin
                        count_next = count_reg + CW'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        sel_next = 1'b0;
                        w_next   = PW'(1);
                        lo_next  = '0;
                        k_next   = '0;
                        if (PW'(count_next) > PW'(1)) begin
                            state_next = ST_RUN;
                        end else begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_RUN: begin
                mid_next   = (lo_w > n_ext) ? n_ext : lo_w;
                hi_next    = (lo_2w > n_ext) ? n_ext : lo_2w;
                i_next     = lo_reg;
                j_next     = (lo_w > n_ext) ? n_ext : lo_w;
                k_next     = lo_reg;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (take_left) begin
                    i_next = i_reg + PW'(1);
                end else begin
                    j_next = j_reg + PW'(1);
                end
                k_next = k_reg + PW'(1);
                if (k_reg + PW'(1) == hi_reg) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_NEXT: begin
                if (lo_adv >= n_ext) begin
                    lo_next  = '0;
                    w_next   = w_dbl;
                    sel_next = !sel_reg;
                    if (w_dbl >= n_ext) begin
                        k_next     = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        state_next = ST_RUN;
                    end
                end else begin
                    lo_next    = lo_adv;
                    state_next = ST_RUN;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_WR;
            end
            ST_OUT_WR: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = src_a;
                    out_last_next  = (k_reg + PW'(1) == n_ext);
                    out_ovf_next   = dropped_reg;
                    if (k_reg + PW'(1) == n_ext) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        sel_next     = 1'b0;
                        state_next   = ST_LOAD;
                    end else begin
                        k_next     = k_reg + PW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg        <= w_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

>>> hdl/ms_ram.sv
module ms_ram
    import ms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
